[src/convex_polygon_point_test_unit_macros.svh]
// assertion macros for the convex polygon point test unit
`ifndef CONVEX_POLYGON_POINT_TEST_UNIT_MACROS_SVH
`define CONVEX_POLYGON_POINT_TEST_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define CPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/cpt_pkg.sv]
// shared types, constants and table builders of the convex polygon point test unit
`default_nettype none

package cpt_pkg;

  localparam int PointDepthDef  = 256;
  localparam int CornerDepthDef = 256;
  localparam int MaxWallsDef    = 32;

  localparam int CoordW = 32;
  localparam int SlotW  = 8;

  typedef enum logic [1:0] {
    OpWrPoint  = 2'd0,
    OpWrCorner = 2'd1,
    OpQuery    = 2'd2
  } op_e;

  // slot modulo table: entry k holds k modulo a depth
  typedef logic [15:0] mod_tbl_t [256];

  typedef struct packed {
    logic              pt_we;
    logic              cn_we;
    logic [SlotW-1:0]  slot;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SlotW-1:0]  pidx;
  } store_wr_t;

  typedef struct packed {
    logic load;
    logic mul_first;
    logic mul_second;
  } cross_ctrl_t;

  function automatic mod_tbl_t build_mod_tbl(int depth);
    mod_tbl_t tbl;
    int       r;
    r = 0;
    for (int k = 0; k < 256; k++) begin
      tbl[k] = 16'(r);
      if (r == depth - 1) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

[src/cpt_store.sv]
// point and corner memories with registered corner-to-point read chain
`default_nettype none

module cpt_store #(
  parameter int POINT_DEPTH  = cpt_pkg::PointDepthDef,
  parameter int CORNER_DEPTH = cpt_pkg::CornerDepthDef,
  localparam int PIdxW = $clog2(POINT_DEPTH),
  localparam int CIdxW = $clog2(CORNER_DEPTH)
) (
  input  logic                      clk_i,
  input  cpt_pkg::store_wr_t        wr_i,
  input  logic [CIdxW-1:0]          corner_addr_i,
  output logic [cpt_pkg::CoordW-1:0] pt_x_o,
  output logic [cpt_pkg::CoordW-1:0] pt_y_o
);
  import cpt_pkg::*;

  localparam mod_tbl_t PMod = build_mod_tbl(POINT_DEPTH);
  localparam mod_tbl_t CMod = build_mod_tbl(CORNER_DEPTH);

  logic [CoordW-1:0] point_x_mem [POINT_DEPTH];
  logic [CoordW-1:0] point_y_mem [POINT_DEPTH];
  logic [SlotW-1:0]  corner_mem  [CORNER_DEPTH];

  logic [SlotW-1:0]  corner_rd_q;
  logic [PIdxW-1:0]  pt_waddr;
  logic [CIdxW-1:0]  cn_waddr;
  logic [PIdxW-1:0]  pt_raddr;

  assign pt_waddr = PMod[wr_i.slot][PIdxW-1:0];
  assign cn_waddr = CMod[wr_i.slot][CIdxW-1:0];
  assign pt_raddr = PMod[corner_rd_q][PIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.pt_we) begin
      point_x_mem[pt_waddr] <= wr_i.x;
      point_y_mem[pt_waddr] <= wr_i.y;
    end
    pt_x_o <= point_x_mem[pt_raddr];
    pt_y_o <= point_y_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cn_we) begin
      corner_mem[cn_waddr] <= wr_i.pidx;
    end
    corner_rd_q <= corner_mem[corner_addr_i];
  end

endmodule

`default_nettype wire

[src/cpt_cross.sv]
// edge differences, shared multiplier and cross product sign compare
`default_nettype none

module cpt_cross (
  input  logic                              clk_i,
  input  cpt_pkg::cross_ctrl_t              ctrl_i,
  input  logic signed [cpt_pkg::CoordW-1:0] t_x_i,
  input  logic signed [cpt_pkg::CoordW-1:0] t_y_i,
  input  logic signed [cpt_pkg::CoordW-1:0] s_x_i,
  input  logic signed [cpt_pkg::CoordW-1:0] s_y_i,
  input  logic signed [cpt_pkg::CoordW-1:0] e_x_i,
  input  logic signed [cpt_pkg::CoordW-1:0] e_y_i,
  output logic                              less_o
);
  import cpt_pkg::*;

  localparam int DiffW = CoordW + 1;
  localparam int ProdW = 2 * DiffW;

  logic signed [DiffW-1:0] ax_q, ay_q, ex_q, ey_q;
  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] p1_q, p2_q;

  // one multiplier, two products per wall
  assign mul_a = ctrl_i.mul_second ? ay_q : ax_q;
  assign mul_b = ctrl_i.mul_second ? ex_q : ey_q;
  assign prod  = ProdW'(mul_a) * ProdW'(mul_b);

  assign less_o = p1_q < p2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ax_q <= DiffW'(t_x_i) - DiffW'(s_x_i);
      ay_q <= DiffW'(t_y_i) - DiffW'(s_y_i);
      ex_q <= DiffW'(e_x_i) - DiffW'(s_x_i);
      ey_q <= DiffW'(e_y_i) - DiffW'(s_y_i);
    end
    if (ctrl_i.mul_first) begin
      p1_q <= prod;
    end
    if (ctrl_i.mul_second) begin
      p2_q <= prod;
    end
  end

endmodule

`default_nettype wire

[src/convex_polygon_point_test_unit.sv]
// top level: request decode, query sequencer, memories and cross product unit
//
//  channel  | handshake            | fields
//  ---------+----------------------+--------------------------------------------------
//  request  | start / busy         | op, slot, coord_x, coord_y, point_index,
//           |                      | first_corner, wall_count
//  result   | done_o strobe        | inside_res_o
//
//  point and corner writes give no result
//  a query of W walls (W clamped to MAX_WALLS) ends after its last wall, or early
//  at the first wall that fails; W = 0 strobes on the next cycle
//  per wall the shared multiplier forms two products, then one compare
//  busy stays high while a query runs; the result strobe lasts one cycle
//  reset clears the state, done and inside registers only; memory contents are undefined until written
`default_nettype none

module convex_polygon_point_test_unit #(
  parameter int POINT_DEPTH  = cpt_pkg::PointDepthDef,
  parameter int CORNER_DEPTH = cpt_pkg::CornerDepthDef,
  parameter int MAX_WALLS    = cpt_pkg::MaxWallsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op_i,
  input  logic [cpt_pkg::SlotW-1:0]         slot_i,
  input  logic signed [cpt_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [cpt_pkg::CoordW-1:0] coord_y_i,
  input  logic [cpt_pkg::SlotW-1:0]         point_index_i,
  input  logic [cpt_pkg::SlotW-1:0]         first_corner_i,
  input  logic [5:0]                        wall_count_i,
  output logic                              inside_res_o,
  output logic                              done_o
);
  import cpt_pkg::*;

  localparam int CIdxW = $clog2(CORNER_DEPTH);
  localparam int WCntW = $clog2(MAX_WALLS + 1);
  localparam mod_tbl_t CMod = build_mod_tbl(CORNER_DEPTH);

  typedef enum logic [9:0] {
    SIdle = 10'b0000000001,
    SFc1  = 10'b0000000010,
    SFc2  = 10'b0000000100,
    SFld  = 10'b0000001000,
    SW1   = 10'b0000010000,
    SW2   = 10'b0000100000,
    SLd   = 10'b0001000000,
    SM1   = 10'b0010000000,
    SM2   = 10'b0100000000,
    SCmp  = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic               done_q, done_d;
  logic               inside_q, inside_d;
  logic [CIdxW-1:0]   ca_q, ca_d, ca_inc;
  logic [WCntW-1:0]   rem_q, rem_d;
  logic [CoordW-1:0]  tx_q, tx_d, ty_q, ty_d;
  logic [CoordW-1:0]  fx_q, fx_d, fy_q, fy_d;
  logic [CoordW-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [CoordW-1:0]  pt_x, pt_y, e_x, e_y;
  logic               accept, less;
  store_wr_t          wr;
  cross_ctrl_t        cctl;

  assign accept = start && !busy;
  assign busy   = (state_q != SIdle);
  assign done_o = done_q;
  assign inside_res_o = inside_q;

  assign ca_inc = (ca_q == CIdxW'(CORNER_DEPTH - 1)) ? '0 : ca_q + 1'b1;
  // last wall closes back to the first corner
  assign e_x = (rem_q == WCntW'(1)) ? fx_q : pt_x;
  assign e_y = (rem_q == WCntW'(1)) ? fy_q : pt_y;

  always_comb begin
    wr.pt_we = accept && (op_i == OpWrPoint);
    wr.cn_we = accept && (op_i == OpWrCorner);
    wr.slot  = slot_i;
    wr.x     = coord_x_i;
    wr.y     = coord_y_i;
    wr.pidx  = point_index_i;
  end

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    inside_d = inside_q;
    ca_d     = ca_q;
    rem_d    = rem_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    cctl     = '0;
    unique case (state_q)
      SIdle: begin
        if (accept && (op_i == OpQuery)) begin
          tx_d = coord_x_i;
          ty_d = coord_y_i;
          ca_d = CMod[first_corner_i][CIdxW-1:0];
          if ({26'b0, wall_count_i} > 32'(MAX_WALLS)) begin
            rem_d = WCntW'(MAX_WALLS);
          end else begin
            rem_d = WCntW'(wall_count_i);
          end
          if (wall_count_i == 6'd0) begin
            done_d   = 1'b1;
            inside_d = 1'b1;
          end else begin
            state_d = SFc1;
          end
        end
      end
      SFc1: state_d = SFc2;
      SFc2: state_d = SFld;
      SFld: begin
        fx_d    = pt_x;
        fy_d    = pt_y;
        sx_d    = pt_x;
        sy_d    = pt_y;
        ca_d    = ca_inc;
        state_d = SW1;
      end
      SW1: state_d = SW2;
      SW2: state_d = SLd;
      SLd: begin
        cctl.load = 1'b1;
        sx_d      = e_x;
        sy_d      = e_y;
        rem_d     = rem_q - 1'b1;
        ca_d      = ca_inc;
        state_d   = SM1;
      end
      SM1: begin
        cctl.mul_first = 1'b1;
        state_d        = SM2;
      end
      SM2: begin
        cctl.mul_second = 1'b1;
        state_d         = SCmp;
      end
      SCmp: begin
        priority if (less) begin
          done_d   = 1'b1;
          inside_d = 1'b0;
          state_d  = SIdle;
        end else if (rem_q == '0) begin
          done_d   = 1'b1;
          inside_d = 1'b1;
          state_d  = SIdle;
        end else begin
          cctl.load = 1'b1;
          sx_d      = e_x;
          sy_d      = e_y;
          rem_d     = rem_q - 1'b1;
          ca_d      = ca_inc;
          state_d   = SM1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      done_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q  <= ca_d;
    rem_q <= rem_d;
    tx_q  <= tx_d;
    ty_q  <= ty_d;
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
  end

  cpt_store #(
    .POINT_DEPTH  (POINT_DEPTH),
    .CORNER_DEPTH (CORNER_DEPTH)
  ) u_store (
    .clk_i         (clk_i),
    .wr_i          (wr),
    .corner_addr_i (ca_q),
    .pt_x_o        (pt_x),
    .pt_y_o        (pt_y)
  );

  cpt_cross u_cross (
    .clk_i  (clk_i),
    .ctrl_i (cctl),
    .t_x_i  (tx_q),
    .t_y_i  (ty_q),
    .s_x_i  (sx_q),
    .s_y_i  (sy_q),
    .e_x_i  (e_x),
    .e_y_i  (e_y),
    .less_o (less)
  );

endmodule

`default_nettype wire

[src/cpt_checker.sv]
// port-level checker of the convex polygon point test unit and its bind
`default_nettype none

`include "convex_polygon_point_test_unit_macros.svh"

module cpt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        op_i,
  input logic [5:0]                        wall_count_i,
  input logic                              inside_res_o,
  input logic                              done_o
);
  import cpt_pkg::*;

  logic req_query, req_other;

  assign req_query = start && !busy && (op_i == OpQuery);
  assign req_other = start && !busy && (op_i != OpQuery);

  // a result never shows while a query is still running
  `CPT_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // write requests produce no result
  `CPT_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, req_other, !done_o)
  // empty polygon answers inside at once
  `CPT_ASSERT_NEXT(a_zero_walls, clk_i, rst_ni, req_query && (wall_count_i == 6'd0),
    done_o && inside_res_o)
  // a real query occupies the sequencer
  `CPT_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, req_query && (wall_count_i != 6'd0),
    busy && !done_o)

endmodule

bind convex_polygon_point_test_unit cpt_checker u_checker (.*);

`default_nettype wire
